### hw/rtl/bfph_pkg.sv
// Shared types and constants for the polynomial-hash Bloom filter.
package bfph_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned RegSetSize   = 0;
  localparam int unsigned RegHashCount = 1;

  // Opcodes of a key.
  localparam logic OpInsert = 1'b0;
  localparam logic OpCheck  = 1'b1;

  // Configuration values in force.
  typedef struct packed {
    logic [16:0] filt_size;
    logic [3:0]  hash_count;
  } bfph_cfg_t;

endpackage

### hw/rtl/bfph_modu.sv
// Iterative 64-bit by 17-bit modulo unit, one quotient bit per cycle.
module bfph_modu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [16:0] remainder
);

  logic [63:0] shreg;
  logic [17:0] rem;
  logic [16:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [17:0] trial;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem[16:0], shreg[63]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
        cnt   <= 7'd64;
      end else if (busy) begin
        shreg <= {shreg[62:0], 1'b0};
        rem   <= (trial >= {1'b0, dvs}) ? trial - {1'b0, dvs} : trial;
        cnt   <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[16:0];

endmodule

### hw/rtl/bloom_filter_poly_hash.sv
// Top level of the polynomial-hash Bloom filter.
// A byte beat updates all MAX_HASHES hashes in turn through the modulo unit, and
// no beat is accepted until the last is written back; a byteless beat skips this.
// A last beat then reduces each active hash again to set or check its filter bit,
// and waits for the result register. Reset is synchronous; a clearing pass then
// zeroes the filter memory, and no beat is accepted until it ends.
module bloom_filter_poly_hash #(
  parameter int FILTER_BITS = 65536,
  parameter int MAX_HASHES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  key_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic        was_insert,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FAW = $clog2(FILTER_BITS);
  localparam int HW  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int HCW = $clog2(MAX_HASHES + 1);
  localparam int SW  = HW + 1;
  localparam logic [16:0] FbMax =
    (FILTER_BITS > 131071) ? 17'h1FFFF : 17'(FILTER_BITS);

  // State codes.
  localparam logic [3:0] SClr = 4'd0, SIdle = 4'd1, SRd = 4'd2, SMul = 4'd3,
                         SMod = 4'd4, SWb = 4'd5, SFin = 4'd6, SFMod = 4'd7,
                         SFRd = 4'd8, SFChk = 4'd9, SOut = 4'd10, SAdd = 4'd11;

  bfph_pkg::bfph_cfg_t cfg;
  logic [3:0]  state;
  logic [HW-1:0] idx;
  logic [FAW-1:0] clr_addr;
  logic        key_started;
  logic        op_r, has_r, last_r, all_ok;
  logic [7:0]  byte_r;
  logic [16:0] m_eff;
  logic [HCW-1:0] n_eff;
  logic        load_out;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filt_size  <= 17'd65536;
      cfg.hash_count <= 4'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'(bfph_pkg::RegHashCount)) cfg.hash_count <= pwdata[3:0];
      else                                       cfg.filt_size  <= pwdata[16:0];
    end
  end
  assign prdata = paddr[2] ? {28'd0, cfg.hash_count} : {15'd0, cfg.filt_size};

  // Effective set size and hash count.
  always_comb begin
    m_eff = cfg.filt_size;
    if (m_eff == 17'd0) m_eff = 17'd1;
    if (m_eff > FbMax)  m_eff = FbMax;
    if (32'(cfg.hash_count) > MAX_HASHES) n_eff = HCW'(MAX_HASHES);
    else n_eff = HCW'(cfg.hash_count);
  end

  // Hash state memory: {accumulator, seed power} per seed.
  logic [80:0] smem [MAX_HASHES];
  logic [80:0] srd;
  logic        swe;
  logic [80:0] swd;
  always_ff @(posedge clk) begin
    if (swe) smem[idx] <= swd;
    srd <= smem[idx];
  end

  // Filter memory, one bit per entry.
  logic fmem [FILTER_BITS];
  logic frd, fwe, fwd;
  logic [FAW-1:0] faddr;
  always_ff @(posedge clk) begin
    if (fwe) fmem[faddr] <= fwd;
    frd <= fmem[faddr];
  end

  // Working registers of one hash update.
  logic [16:0] acc;
  logic [63:0] pw, pws, prod, sum;
  logic [SW-1:0] seed;
  logic        mstart, mdone;
  logic [63:0] mdiv;
  logic [16:0] mrem;
  logic [16:0] hidx;

  bfph_modu u_mod (
    .clk(clk), .rst(rst), .start(mstart), .dividend(mdiv),
    .divisor(m_eff), .done(mdone), .remainder(mrem)
  );

  // A fresh key starts from a zero hash and a unit seed power.
  assign acc       = srd[80:64];
  assign pws       = key_started ? srd[63:0] : 64'd1;
  assign seed      = SW'(idx) + 1'b1;
  assign in_stall  = (state != SIdle);
  assign mstart    = (state == SAdd) || (state == SFin);
  assign mdiv      = (state == SFin) ? (key_started ? {47'd0, acc} : 64'd0) : sum;
  assign sum       = {47'd0, (key_started ? acc : 17'd0)} + prod;
  assign swe       = (state == SWb);
  assign swd       = {mrem, pw * seed};
  assign hidx      = mrem;
  assign load_out  = (state == SOut) && (!out_valid || !out_stall);

  always_comb begin
    fwe = 1'b0;
    fwd = 1'b0;
    faddr = FAW'(hidx);
    if (state == SClr) begin
      fwe = 1'b1;
      faddr = clr_addr;
    end else if (state == SFMod && mdone && op_r == bfph_pkg::OpInsert) begin
      fwe = 1'b1;
      fwd = 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SClr;
      clr_addr    <= '0;
      key_started <= 1'b0;
      out_valid   <= 1'b0;
      idx         <= '0;
    end else begin
      case (state)
        SClr: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == FAW'(FILTER_BITS - 1)) state <= SIdle;
        end
        SIdle: begin
          if (in_valid) begin
            op_r <= opcode; byte_r <= key_byte;
            has_r <= has_byte; last_r <= last_byte;
            idx <= '0;
            all_ok <= 1'b1;
            state <= SRd;
          end
        end
        SRd: begin
          // Memory read in flight; a beat without a byte leaves the hashes alone.
          if (!has_r) state <= last_r ? SFRd : SIdle;
          else state <= SMul;
        end
        SMul: begin
          pw   <= pws;
          state <= SAdd;
        end
        SAdd: state <= SMod;
        SMod: if (mdone) state <= SWb;
        SWb: begin
          if (32'(idx) == MAX_HASHES - 1) begin
            idx <= '0;
            key_started <= 1'b1;
            state <= last_r ? SFRd : SIdle;
          end else begin
            idx <= idx + 1'b1;
            state <= SRd;
          end
        end
        SFRd: begin
          if (n_eff == '0) state <= SOut;
          else state <= SFin;
        end
        SFin: state <= SFMod;
        SFMod: if (mdone) state <= SFChk;
        SFChk: begin
          if (!frd) all_ok <= 1'b0;
          if (HCW'(idx) + 1'b1 >= n_eff) state <= SOut;
          else begin
            idx <= idx + 1'b1;
            state <= SFRd;
          end
        end
        SOut: begin
          // The result register frees the sequencer once it takes the beat.
          if (load_out) begin
            found      <= (op_r == bfph_pkg::OpCheck) && all_ok;
            was_insert <= (op_r == bfph_pkg::OpInsert);
            key_started <= 1'b0;
            state <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase

      // Result register: loaded from the sequencer, emptied when taken.
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Product of the sign-extended byte and the seed power, registered.
  // The sign bit weighs -128, so an unsigned 8-bit product and a shifted subtract suffice.
  always_ff @(posedge clk) begin
    if (state == SMul)
      prod <= pws * byte_r - (byte_r[7] ? {pws[55:0], 8'd0} : 64'd0);
  end

  // Checks on the sequencer.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != SIdle) |-> in_stall) else $error("accept while busy");
  a_found_check: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> !was_insert) else $error("insert reported found");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

### tb/sv/bloom_filter_poly_hash_tb.sv
// Testbench for the polynomial-hash Bloom filter: directed table, random keys, predictor check.
`timescale 1ns / 100ps

module bloom_filter_poly_hash_tb;

  localparam int FilterBits = 65536;
  localparam int MaxHashes  = 8;
  localparam int IdleCycles = 1500;
  localparam longint CycleLimit = 30000000;

  // One directed row: the beat and, where typed in, the result it must give.
  typedef struct {
    logic       op;
    logic [7:0] kb;
    logic       hb;
    logic       lb;
    bit         typed;
    bit         t_found;
    bit         t_ins;
  } row_t;

  typedef struct {
    bit found;
    bit ins;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = bfph_pkg::OpInsert;
  logic [7:0]  key_byte = 8'd0;
  logic        has_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic        was_insert;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  bloom_filter_poly_hash dut (.*);

  always #5 clk = ~clk;

  // Predictor state: per-seed hashes, seed powers, filter bits, registers.
  int unsigned     hsum [MaxHashes];
  longint unsigned spow [MaxHashes];
  bit              fbits [FilterBits];
  bit              in_key;
  bit [16:0]       size_reg;
  bit [3:0]        count_reg;

  verdict_t verdicts [$];
  int       errors;
  int       burst_left;
  longint   cycles;
  int       hold_left;
  int       stall_mode;
  bit       hold_req;

  // Recently inserted keys, reused by checks so that hits occur.
  bit [7:0] saved_bytes [$][$];

  function automatic longint unsigned modulus();
    if (size_reg == 0) return 1;
    if (size_reg > FilterBits) return FilterBits;
    return size_reg;
  endfunction

  // Advances the filter by one accepted beat; returns 1 when a key finishes.
  function automatic bit filter_step(input logic op, input logic [7:0] kb, input logic hb,
                                     input logic lb, output verdict_t v);
    longint unsigned m, b, h, idx;
    int n;
    bit all_set;
    m = modulus();
    if (!in_key) begin
      for (int i = 0; i < MaxHashes; i++) begin
        hsum[i] = 0;
        spow[i] = 1;
      end
      in_key = 1;
    end
    if (hb) begin
      b = {{56{kb[7]}}, kb};
      for (int i = 0; i < MaxHashes; i++) begin
        h = longint'(hsum[i]) + b * spow[i];
        hsum[i] = int'(h % m);
        spow[i] = spow[i] * longint'(i + 1);
      end
    end
    v = '{0, 0};
    if (!lb) return 0;
    in_key = 0;
    n = (count_reg > MaxHashes) ? MaxHashes : count_reg;
    all_set = 1;
    for (int i = 0; i < n; i++) begin
      idx = longint'(hsum[i]) % m;
      if (op == bfph_pkg::OpInsert) fbits[idx] = 1;
      else if (!fbits[idx]) all_set = 0;
    end
    v.found = (op == bfph_pkg::OpCheck) && all_set;
    v.ins = (op == bfph_pkg::OpInsert);
    return 1;
  endfunction

  // Register write over the configuration port; the predictor follows it.
  task automatic write_reg(input int unsigned idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx == bfph_pkg::RegSetSize) size_reg = val[16:0];
    else count_reg = val[3:0];
  endtask

  // Offers one beat in bursts, waits for it to be taken, and books the outcome.
  task automatic send_beat(input logic op, input logic [7:0] kb, input logic hb,
                           input logic lb, input bit typed, input verdict_t tv);
    verdict_t v;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    opcode <= op;
    key_byte <= kb;
    has_byte <= hb;
    last_byte <= lb;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (filter_step(op, kb, hb, lb, v)) verdicts.push_back(typed ? tv : v);
  endtask

  // Block is idle: nothing expected and the last beat has had time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  // One random key, mostly well formed, sometimes noisy or a repeat of an insert.
  task automatic send_key();
    bit [7:0] kbytes [$];
    logic op;
    int len;
    op = $urandom_range(0, 1) ? bfph_pkg::OpCheck : bfph_pkg::OpInsert;
    if (op == bfph_pkg::OpCheck && saved_bytes.size() > 0 && $urandom_range(0, 1))
      kbytes = saved_bytes[$urandom_range(0, saved_bytes.size() - 1)];
    else begin
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) kbytes.push_back(8'($urandom_range(0, 255)));
    end
    if (op == bfph_pkg::OpInsert) begin
      saved_bytes.push_back(kbytes);
      if (saved_bytes.size() > 32) void'(saved_bytes.pop_front());
    end
    if (kbytes.size() == 0) begin
      send_beat(op, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 0, '{0, 0});
      return;
    end
    foreach (kbytes[i]) begin
      // Occasional byteless beat inside the key.
      if ($urandom_range(0, 9) == 0)
        send_beat(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                  0, '{0, 0});
      send_beat(i == kbytes.size() - 1 ? op : logic'($urandom_range(0, 1)), kbytes[i],
                1'b1, i == kbytes.size() - 1, 0, '{0, 0});
    end
  endtask

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result found=%0b was_insert=%0b", $time, found, was_insert);
        errors++;
      end else begin
        if (found !== verdicts[0].found) begin
          $display("%0t: found expected %0b actual %0b", $time, verdicts[0].found, found);
          errors++;
        end
        if (was_insert !== verdicts[0].ins) begin
          $display("%0t: was_insert expected %0b actual %0b", $time, verdicts[0].ins,
                   was_insert);
          errors++;
        end
        void'(verdicts.pop_front());
      end
    end
  end

  // Receiver stall pattern, with one long hold while the sender keeps going.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (hold_req && hold_left == 0) begin
      hold_left = 30000;
      hold_req = 0;
    end
    if ($urandom_range(0, 499) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_mode == 0) out_stall <= 1'b0;
    else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  row_t table_rows [] = '{
    '{bfph_pkg::OpCheck,  8'h00, 1'b0, 1'b1, 1, 0, 0},  // empty filter misses the empty key
    '{bfph_pkg::OpInsert, 8'h00, 1'b0, 1'b1, 1, 0, 1},
    '{bfph_pkg::OpCheck,  8'h5A, 1'b0, 1'b1, 1, 1, 0},  // empty key now present
    '{bfph_pkg::OpInsert, 8'h00, 1'b1, 1'b1, 1, 0, 1},  // zero byte
    '{bfph_pkg::OpCheck,  8'h00, 1'b1, 1'b1, 0, 0, 0},
    '{bfph_pkg::OpInsert, 8'h7F, 1'b1, 1'b0, 0, 0, 0},
    '{bfph_pkg::OpCheck,  8'h80, 1'b1, 1'b1, 0, 0, 0},
    '{bfph_pkg::OpCheck,  8'h7F, 1'b1, 1'b0, 0, 0, 0},
    '{bfph_pkg::OpCheck,  8'h80, 1'b1, 1'b1, 0, 0, 0},
    '{bfph_pkg::OpCheck,  8'hFF, 1'b1, 1'b0, 0, 0, 0},
    '{bfph_pkg::OpInsert, 8'h33, 1'b0, 1'b0, 0, 0, 0},  // byteless beat inside a key
    '{bfph_pkg::OpCheck,  8'hFF, 1'b1, 1'b1, 0, 0, 0},
    '{bfph_pkg::OpInsert, 8'hFF, 1'b1, 1'b0, 0, 0, 0},
    '{bfph_pkg::OpInsert, 8'hFF, 1'b1, 1'b1, 1, 0, 1},
    '{bfph_pkg::OpCheck,  8'hFF, 1'b1, 1'b0, 0, 0, 0},
    '{bfph_pkg::OpCheck,  8'hFF, 1'b1, 1'b1, 1, 1, 0},
    '{bfph_pkg::OpCheck,  8'h01, 1'b1, 1'b0, 0, 0, 0}   // left open across the next setting
  };

  // Register settings per phase: extremes first, then random ones.
  bit [16:0] phase_size [] = '{17'd0, 17'h1FFFF, 17'd1, 17'd65536, 17'd64, 17'd300};
  bit [3:0]  phase_count [] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd2, 4'd3};

  initial begin
    bit [16:0] sz;
    bit [3:0]  cnt;
    int sent;
    for (int i = 0; i < FilterBits; i++) fbits[i] = 0;
    in_key = 0;
    size_reg = 17'd65536;
    count_reg = 4'd4;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset settings.
    foreach (table_rows[i])
      send_beat(table_rows[i].op, table_rows[i].kb, table_rows[i].hb, table_rows[i].lb,
                table_rows[i].typed, '{table_rows[i].t_found, table_rows[i].t_ins});
    drain();

    // Random phases, each under a new setting; phases may end inside a key.
    for (int p = 0; p < 12; p++) begin
      if (p < phase_size.size()) begin
        sz = phase_size[p];
        cnt = phase_count[p];
      end else begin
        sz = 17'($urandom_range(0, 131071));
        if ($urandom_range(0, 1)) sz = 17'($urandom_range(1, 2000));
        cnt = 4'($urandom_range(0, 15));
      end
      write_reg(bfph_pkg::RegSetSize, 32'(sz));
      write_reg(bfph_pkg::RegHashCount, 32'(cnt));
      sent = 0;
      if (p == 3) hold_req = 1;
      while (sent < 150) begin
        send_key();
        sent += 3;
      end
      if ($urandom_range(0, 1))
        send_beat(bfph_pkg::OpInsert, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 0, '{0, 0});
      drain();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
